@@ design/drpc_pkg.sv @@
package drpc_pkg;

    localparam int RANGE_W    = 10;
    localparam int MAX_DIGITS = 4;
    localparam int LIMIT_W    = 14;

    // result status codes
    localparam logic [1:0] STATUS_PREFIX   = 2'd0;
    localparam logic [1:0] STATUS_NO_RANGE = 2'd1;
    localparam logic [1:0] STATUS_INVALID  = 2'd2;

    typedef logic [MAX_DIGITS-1:0][3:0] bcd_word_t;

    typedef struct packed {
        logic               range_present;
        logic [RANGE_W-1:0] range_low;
        logic [RANGE_W-1:0] range_high;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [RANGE_W-1:0] prefix_value;
        logic [1:0]         prefix_length;
        logic               last;
    } rsp_t;

    // classified range, bounds in BCD
    typedef struct packed {
        logic [1:0] status;
        bcd_word_t  lo_bcd;
        bcd_word_t  hi_bcd;
    } cmd_t;

    function automatic int pow10(input int n);
        int r;
        r = 1;
        for (int i = 0; i < n; i++)
        begin
            r = r * 10;
        end
        return r;
    endfunction

endpackage

@@ design/drpc_front.sv @@
module drpc_front #(
    parameter int DIGITS = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             range_valid,
    output logic             range_stall,
    input  drpc_pkg::req_t   range_item,
    output logic             cmd_valid,
    input  logic             cmd_full,
    output drpc_pkg::cmd_t   cmd
);

    localparam int LIMIT = drpc_pkg::pow10(DIGITS) - 1;
    localparam logic [drpc_pkg::LIMIT_W-1:0] LIMIT_L = drpc_pkg::LIMIT_W'(LIMIT);
    localparam int CNT_W = $clog2(drpc_pkg::RANGE_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(drpc_pkg::RANGE_W - 1);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_CONVERT = 2'd1;
    localparam logic [1:0] ST_PUSH    = 2'd2;

    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [1:0]                   status_reg;
    logic [drpc_pkg::RANGE_W-1:0] lo_bin_reg;
    logic [drpc_pkg::RANGE_W-1:0] hi_bin_reg;
    drpc_pkg::bcd_word_t          lo_bcd_reg;
    drpc_pkg::bcd_word_t          hi_bcd_reg;
    logic [1:0]                   status_in;
    logic                         accept;

    // one double-dabble step: adjust digits, shift in the next binary bit
    function automatic drpc_pkg::bcd_word_t dd_step(input drpc_pkg::bcd_word_t b,
                                                    input logic bit_in);
        drpc_pkg::bcd_word_t                   a;
        logic [4*drpc_pkg::MAX_DIGITS:0]       w;
        for (int i = 0; i < drpc_pkg::MAX_DIGITS; i++)
        begin
            a[i] = (b[i] >= 4'd5) ? b[i] + 4'd3 : b[i];
        end
        w = {a, bit_in};
        return w[4*drpc_pkg::MAX_DIGITS-1:0];
    endfunction

    assign range_stall = (state_reg != ST_IDLE);
    assign accept      = range_valid && !range_stall;
    assign cmd_valid   = (state_reg == ST_PUSH);

    always_comb
    begin
        if (!range_item.range_present)
        begin
            status_in = drpc_pkg::STATUS_NO_RANGE;
        end
        else if (({4'b0, range_item.range_high} > LIMIT_L)
                 || (range_item.range_low > range_item.range_high))
        begin
            status_in = drpc_pkg::STATUS_INVALID;
        end
        else
        begin
            status_in = drpc_pkg::STATUS_PREFIX;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CONVERT;
                    count_next = '0;
                end
            end
            ST_CONVERT:
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == LAST_STEP)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!cmd_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // hold the range and convert both bounds, one bit a cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_in;
            lo_bin_reg <= range_item.range_low;
            hi_bin_reg <= range_item.range_high;
            lo_bcd_reg <= '0;
            hi_bcd_reg <= '0;
        end
        else if (state_reg == ST_CONVERT)
        begin
            lo_bcd_reg <= dd_step(lo_bcd_reg, lo_bin_reg[drpc_pkg::RANGE_W-1]);
            hi_bcd_reg <= dd_step(hi_bcd_reg, hi_bin_reg[drpc_pkg::RANGE_W-1]);
            lo_bin_reg <= {lo_bin_reg[drpc_pkg::RANGE_W-2:0], 1'b0};
            hi_bin_reg <= {hi_bin_reg[drpc_pkg::RANGE_W-2:0], 1'b0};
        end
    end

    assign cmd.status = status_reg;
    assign cmd.lo_bcd = lo_bcd_reg;
    assign cmd.hi_bcd = hi_bcd_reg;

endmodule

@@ design/drpc_queue.sv @@
module drpc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_full,
    input  drpc_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output drpc_pkg::cmd_t pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

    drpc_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              push_en;
    logic              pop_en;

    assign push_full = (fill_reg == FULL_FILL);
    assign pop_valid = (fill_reg != '0);
    assign push_en   = push_valid && !push_full;
    assign pop_en    = pop_ready && pop_valid;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push_en && !pop_en)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop_en && !push_en)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/drpc_back.sv @@
module drpc_back #(
    parameter int DIGITS = 3
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    input  drpc_pkg::cmd_t cmd,
    output logic           prefix_valid,
    input  logic           prefix_stall,
    output drpc_pkg::rsp_t prefix_item
);

    localparam int K_W = $clog2(DIGITS + 1);
    localparam int ACC_W = drpc_pkg::LIMIT_W;
    localparam logic [2:0] DIGITS_L = 3'(DIGITS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                        state_reg;
    logic                        state_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    drpc_pkg::rsp_t              out_reg;
    drpc_pkg::rsp_t              out_next;
    logic [1:0]                  status_reg;
    logic [DIGITS-1:0][3:0]      cur_reg;
    logic [DIGITS-1:0][3:0]      lo_reg;

    logic                        slot_free;
    logic                        emit;
    logic                        nines;
    logic [DIGITS-1:0][3:0]      base_k;
    logic [K_W-1:0]              sel_k;
    logic [DIGITS-1:0][3:0]      base_sel;
    logic [DIGITS-1:0][3:0]      cur_dec;
    logic                        borrow;
    logic [ACC_W-1:0]            acc;
    logic [2:0]                  len_full;
    logic                        last_hit;

    assign slot_free = !out_valid_reg || !prefix_stall;
    assign emit      = (state_reg == ST_WALK) && slot_free;
    assign cmd_pop   = (state_reg == ST_IDLE);

    // widest block ending at the current top: its low digits are all nines and
    // its base stays at or above the lower bound
    always_comb
    begin
        nines  = 1'b1;
        sel_k  = '0;
        base_k = cur_reg;
        for (int k = 1; k <= DIGITS; k++)
        begin
            nines = nines && (cur_reg[k-1] == 4'd9);
            base_k[k-1] = 4'd0;
            if (nines && (base_k >= lo_reg))
            begin
                sel_k = K_W'(k);
            end
        end
    end

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            base_sel[i] = (i < int'(sel_k)) ? 4'd0 : cur_reg[i];
        end
        for (int i = DIGITS - 1; i >= 0; i--)
        begin
            if (i >= int'(sel_k))
            begin
                acc = (acc << 3) + (acc << 1) + ACC_W'(cur_reg[i]);
            end
        end
        // step the top just below the block just covered
        borrow = 1'b1;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (borrow && (base_sel[i] == 4'd0))
            begin
                cur_dec[i] = 4'd9;
            end
            else if (borrow)
            begin
                cur_dec[i] = base_sel[i] - 4'd1;
                borrow     = 1'b0;
            end
            else
            begin
                cur_dec[i] = base_sel[i];
            end
        end
        len_full = DIGITS_L - 3'(sel_k);
        last_hit = (base_sel == lo_reg);
    end

    always_comb
    begin
        if (status_reg != drpc_pkg::STATUS_PREFIX)
        begin
            out_next.status        = status_reg;
            out_next.prefix_value  = '0;
            out_next.prefix_length = '0;
            out_next.last          = 1'b1;
        end
        else
        begin
            out_next.status        = drpc_pkg::STATUS_PREFIX;
            out_next.prefix_value  = acc[drpc_pkg::RANGE_W-1:0];
            out_next.prefix_length = len_full[1:0];
            out_next.last          = last_hit;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!prefix_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (emit && (out_next.last))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && cmd_valid)
        begin
            status_reg <= cmd.status;
            cur_reg    <= cmd.hi_bcd[DIGITS-1:0];
            lo_reg     <= cmd.lo_bcd[DIGITS-1:0];
        end
        else if (emit)
        begin
            cur_reg <= cur_dec;
        end
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    assign prefix_valid = out_valid_reg;
    assign prefix_item  = out_reg;

endmodule

@@ design/decimal_range_prefix_cover.sv @@
// Decimal range prefix cover. Each range transaction on the range channel
// carries an inclusive range of DIGITS-digit decimal numbers; the block answers
// with the fewest decimal digit prefixes whose zero-padded completions cover
// exactly that range, one prefix transaction each, in descending order of the
// numbers they cover, with last set on the final one. The full range yields a
// single prefix of length zero. An absent range gives one no-range result, and
// an upper bound above 10^DIGITS-1 or a lower bound above the upper one gives
// one invalid result. The front end takes a range, converts both bounds to BCD
// one bit a cycle and hands it to a two-entry queue; it takes no new range until
// the last one has been handed to the queue. The back end loads a range from the
// queue while idle and then produces one prefix a cycle while the prefix channel
// does not stall; back-pressure on the prefix channel holds the walk in place.
module decimal_range_prefix_cover #(
    parameter int DIGITS = 3
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           range_valid,
    output logic           range_stall,
    input  drpc_pkg::req_t range_item,
    output logic           prefix_valid,
    input  logic           prefix_stall,
    output drpc_pkg::rsp_t prefix_item
);

    logic           push_valid;
    logic           push_full;
    drpc_pkg::cmd_t push_data;
    logic           pop_valid;
    logic           pop_ready;
    drpc_pkg::cmd_t pop_data;

    // classify the range and convert its bounds
    drpc_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .range_valid (range_valid),
        .range_stall (range_stall),
        .range_item  (range_item),
        .cmd_valid   (push_valid),
        .cmd_full    (push_full),
        .cmd         (push_data)
    );

    // decouple the two halves so that each may stall on its own
    drpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // walk the range from its top, one prefix a cycle unless the prefix channel stalls
    drpc_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (pop_valid),
        .cmd_pop      (pop_ready),
        .cmd          (pop_data),
        .prefix_valid (prefix_valid),
        .prefix_stall (prefix_stall),
        .prefix_item  (prefix_item)
    );

endmodule

@@ tb/decimal_range_prefix_cover_tb.sv @@
module decimal_range_prefix_cover_tb;

    localparam int DIGITS         = 3;
    localparam int MAX_PREFIXES   = 44;
    // Cycles with no transaction on either channel before the run is declared hung.
    // The slowest legitimate quiet stretch is a range conversion plus a long
    // random stall streak; this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 3000;
    // Settling time after the last expected prefix: one full front end pass plus
    // the longest back end walk.
    localparam int DRAIN_CYCLES   = 60;

    // Scoreboard: turns each accepted range into the prefixes it must produce and
    // checks prefix transactions against them in order.
    class prefix_cover_book;

        drpc_pkg::rsp_t expected_prefixes[$];
        int             errors;

        function new();
            errors = 0;
        endfunction

        function void push_prefix(logic [1:0] status, int value, int length, logic last);
            drpc_pkg::rsp_t p;
            p.status        = status;
            p.prefix_value  = value[drpc_pkg::RANGE_W-1:0];
            p.prefix_length = length[1:0];
            p.last          = last;
            expected_prefixes.insert(expected_prefixes.size(), p);
        endfunction

        // Work out the cover of one range: walk the digit trie depth first,
        // highest digit first, and emit each subtree that lies wholly inside.
        function void note_range(drpc_pkg::req_t r);
            int stack_depth[$];
            int stack_pfx[$];
            int depth;
            int pfx;
            int span;
            int base;
            int top;
            int lo;
            int hi;
            int emitted;
            lo      = int'(r.range_low);
            hi      = int'(r.range_high);
            emitted = 0;
            if (!r.range_present)
            begin
                push_prefix(drpc_pkg::STATUS_NO_RANGE, 0, 0, 1'b1);
                return;
            end
            if (hi > 10 ** DIGITS - 1 || lo > hi)
            begin
                push_prefix(drpc_pkg::STATUS_INVALID, 0, 0, 1'b1);
                return;
            end
            stack_depth.push_front(0);
            stack_pfx.push_front(0);
            while (stack_depth.size() != 0)
            begin
                depth = stack_depth.pop_front();
                pfx   = stack_pfx.pop_front();
                span  = 10 ** (DIGITS - depth);
                base  = pfx * span;
                top   = base + span - 1;
                if (top < lo || base > hi)
                    continue;
                if (lo <= base && top <= hi)
                begin
                    if (emitted < MAX_PREFIXES)
                    begin
                        push_prefix(drpc_pkg::STATUS_PREFIX, pfx, depth, 1'b0);
                        emitted++;
                    end
                    continue;
                end
                if (depth >= DIGITS)
                    continue;
                // stack digit 0 first so that digit 9 comes off the stack first
                for (int c = 0; c <= 9; c++)
                begin
                    stack_depth.push_front(depth + 1);
                    stack_pfx.push_front(pfx * 10 + c);
                end
            end
            if (emitted == 0)
            begin
                push_prefix(drpc_pkg::STATUS_INVALID, 0, 0, 1'b1);
                return;
            end
            expected_prefixes[expected_prefixes.size() - 1].last = 1'b1;
        endfunction

        function void check_prefix(drpc_pkg::rsp_t got);
            drpc_pkg::rsp_t want;
            if (expected_prefixes.size() == 0)
            begin
                $error("unexpected prefix: status %0d value %0d length %0d last %0d",
                       got.status, got.prefix_value, got.prefix_length, got.last);
                errors++;
                return;
            end
            want = expected_prefixes.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.prefix_value !== want.prefix_value)
            begin
                $error("prefix_value: expected %0d, got %0d",
                       want.prefix_value, got.prefix_value);
                errors++;
            end
            if (got.prefix_length !== want.prefix_length)
            begin
                $error("prefix_length: expected %0d, got %0d",
                       want.prefix_length, got.prefix_length);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction

    endclass

    logic           clk          = 1'b0;
    logic           rst_n        = 1'b0;
    logic           range_valid  = 1'b0;
    logic           range_stall;
    drpc_pkg::req_t range_item   = '0;
    logic           prefix_valid;
    logic           prefix_stall = 1'b0;
    drpc_pkg::rsp_t prefix_item;

    // Idling odds in percent, changed per phase by the stimulus process.
    int   send_idle_pct  = 0;
    int   stall_pct      = 0;
    int   quiet_cycles   = 0;

    prefix_cover_book book;

    decimal_range_prefix_cover #(
        .DIGITS (DIGITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .range_valid  (range_valid),
        .range_stall  (range_stall),
        .range_item   (range_item),
        .prefix_valid (prefix_valid),
        .prefix_stall (prefix_stall),
        .prefix_item  (prefix_item)
    );

    always #6 clk = ~clk;

    // Monitor both channels on the rising edge; every value read here is the one
    // settled before the edge, since all drivers use nonblocking assignments.
    // Also drive the random stall of the prefix channel and keep the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (range_valid && !range_stall)
                book.note_range(range_item);
            if (prefix_valid && !prefix_stall)
                book.check_prefix(prefix_item);
            prefix_stall <= ($urandom_range(0, 99) < stall_pct);

            if ((range_valid && !range_stall) || (prefix_valid && !prefix_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("decimal_range_prefix_cover: mismatch");
                $finish;
            end
        end
    end

    function automatic drpc_pkg::req_t make_range(logic present, int lo, int hi);
        drpc_pkg::req_t r;
        r.range_present = present;
        r.range_low     = lo[drpc_pkg::RANGE_W-1:0];
        r.range_high    = hi[drpc_pkg::RANGE_W-1:0];
        return r;
    endfunction

    // Mostly well-formed ranges, some aligned to digit boundaries so that long
    // prefixes collapse into short ones; the rest absent or with random bounds.
    function automatic drpc_pkg::req_t random_range();
        int pick;
        int lo;
        int hi;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return make_range(1'b0, $urandom_range(0, 1023), $urandom_range(0, 1023));
        if (pick < 18)
            return make_range(1'b1, $urandom_range(0, 1023), $urandom_range(0, 1023));
        if (pick < 38)
        begin
            lo = $urandom_range(0, 99) * 10;
            hi = $urandom_range(lo, 999);
            hi = (hi / 10) * 10 + 9;
            return make_range(1'b1, lo, hi);
        end
        if (pick < 55)
        begin
            lo = $urandom_range(0, 999);
            hi = lo + $urandom_range(0, 20);
            if (hi > 999)
                hi = 999;
            return make_range(1'b1, lo, hi);
        end
        lo = $urandom_range(0, 999);
        hi = $urandom_range(lo, 999);
        return make_range(1'b1, lo, hi);
    endfunction

    // Offer one range transaction and hold it until accepted. Idle cycles come
    // first; valid is left high after acceptance so a back-to-back transaction
    // never lowers and raises it in the same step.
    task automatic send_range(input drpc_pkg::req_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            range_valid <= 1'b0;
            @(posedge clk);
        end
        range_valid <= 1'b1;
        range_item  <= r;
        @(posedge clk);
        while (range_stall)
            @(posedge clk);
    endtask

    initial
    begin
        book = new();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no range: bounds must be ignored
        send_range(make_range(1'b0, 0, 0));
        send_range(make_range(1'b0, 1023, 1023));
        send_range(make_range(1'b0, 500, 3));
        // full range collapses to the empty prefix; single numbers give one prefix
        send_range(make_range(1'b1, 0, 999));
        send_range(make_range(1'b1, 0, 0));
        send_range(make_range(1'b1, 999, 999));
        // ranges that need the most prefixes, aligned ranges that need one, a mid span
        send_range(make_range(1'b1, 1, 998));
        send_range(make_range(1'b1, 0, 998));
        send_range(make_range(1'b1, 1, 999));
        send_range(make_range(1'b1, 100, 199));
        send_range(make_range(1'b1, 10, 19));
        send_range(make_range(1'b1, 123, 876));
        // upper bound beyond three digits
        send_range(make_range(1'b1, 0, 1000));
        send_range(make_range(1'b1, 0, 1023));
        send_range(make_range(1'b1, 1023, 1023));
        send_range(make_range(1'b1, 1000, 1000));
        // reversed bounds, then small and mid-range spans
        send_range(make_range(1'b1, 500, 499));
        send_range(make_range(1'b1, 999, 0));
        send_range(make_range(1'b1, 5, 5));
        send_range(make_range(1'b1, 990, 999));
        send_range(make_range(1'b1, 511, 512));
        send_range(make_range(1'b1, 682, 853));

        // Random phases: no idling, idle sender, stalling receiver, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 69;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 69;
                end
                default:
                begin
                    send_idle_pct = 33;
                    stall_pct     = 33;
                end
            endcase
            repeat (65)
                send_range(random_range());
        end
        range_valid <= 1'b0;

        // Let the monitor note the final range, drain every expected prefix,
        // then allow stray transactions to surface.
        @(posedge clk);
        while (book.expected_prefixes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (book.errors == 0 && book.expected_prefixes.size() == 0)
            $display("decimal_range_prefix_cover: match");
        else
            $display("decimal_range_prefix_cover: mismatch");
        $finish;
    end

endmodule
